// File: src/gcn_pkg.sv
// Package with the types and constants of the gradient clip-by-norm unit.
package gcn_pkg;

  localparam int unsigned VAL_W     = 24;  // signed Q8.16 element
  localparam int unsigned MAXN_W    = 26;  // unsigned Q10.16 limit
  localparam int unsigned NORM_W    = 27;  // unsigned Q11.16 norm
  localparam int unsigned SUM_W     = 53;  // unsigned Q21.32 square sum
  localparam int unsigned PROD_W    = VAL_W + MAXN_W;
  localparam int unsigned UNIT_W    = SUM_W + 1;
  localparam int unsigned SQRT_STEPS = (SUM_W + 1) / 2;
  localparam int unsigned DIV_STEPS = VAL_W;
  localparam int unsigned STEP_W    = 5;

  localparam logic [MAXN_W-1:0] MAX_NORM_RST = MAXN_W'(65536);
  localparam logic [SUM_W-1:0]  SQRT_BIT0    = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SQRT,
    S_RD,
    S_MUL,
    S_DIV,
    S_OUT
  } gcn_state_e;

  typedef struct packed {
    logic              ge;
    logic [UNIT_W-1:0] diff;
  } cs_res_t;

endpackage

// File: src/gradient_clip_by_norm_unit.sv
// Top level of the gradient clip-by-norm unit: store, norm, scaling and output.
//
//  channel | direction | handshake                  | item contents
//  --------+-----------+----------------------------+-------------------------------------------
//  in      | input     | in_valid_i / in_ready_o    | grad_value_i, is_last_i
//  out     | output    | out_valid_o / out_ready_i  | out_value_o, out_last_o, vector_norm_o,
//          |           |                            | was_clipped_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | max_norm_i
//
// An input item is accepted and stored in S_IDLE, and its square is added in S_ACC.
// The item that closes a vector then starts the square root: 27 steps, one step per
// cycle through the shared compare-and-subtract unit. Each element then passes through
// a read state, a multiply state, 24 divide steps when clipping applies, and the
// output state. A stall on the output holds the whole block; no input item is
// taken until the last result of the vector is delivered. Reset clears the control
// state and loads the norm limit with 1.0; the element store needs no clearing.
module gradient_clip_by_norm_unit
  import gcn_pkg::*;
#(
  parameter int unsigned VEC_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [MAXN_W-1:0]        max_norm_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [VAL_W-1:0]  grad_value_i,
  input  logic                     is_last_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [VAL_W-1:0]  out_value_o,
  output logic                     out_last_o,
  output logic [NORM_W-1:0]        vector_norm_o,
  output logic                     was_clipped_o
);

  localparam int unsigned AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int unsigned CW = $clog2(VEC_DEPTH + 1);

  gcn_state_e state_q, state_d;

  logic [MAXN_W-1:0] max_norm_q, max_norm_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [VAL_W-1:0]  mag_q, mag_d;
  logic              flush_q, flush_d;
  logic [SUM_W-1:0]  x_q, x_d;
  logic [SUM_W-1:0]  root_q, root_d;
  logic [SUM_W-1:0]  bit_q, bit_d;
  logic [NORM_W-1:0] norm_q, norm_d;
  logic              clip_q, clip_d;
  logic [NORM_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0]  low_q, low_d;
  logic              neg_q, neg_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  logic              out_last_q, out_last_d;

  logic [VAL_W-1:0]  store_q [VEC_DEPTH];
  logic [VAL_W-1:0]  rd_q;

  logic              in_fire;
  logic              out_fire;
  logic [UNIT_W-1:0] unit_a;
  logic [UNIT_W-1:0] unit_b;
  cs_res_t           unit_res;
  logic [2*VAL_W-1:0] square;
  logic [VAL_W-1:0]  rd_mag;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  quot;
  logic              elem_last;

  // The norm limit is only taken while idle, so a run in progress keeps its limit.
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_fire    = out_valid_o && out_ready_i;

  assign out_value_o   = out_value_q;
  assign out_last_o    = out_last_q;
  assign vector_norm_o = norm_q;
  assign was_clipped_o = clip_q;

  // Element store: written at the fill position, read at the emit position.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      store_q[count_q[AW-1:0]] <= grad_value_i;
    end
    rd_q <= store_q[idx_q[AW-1:0]];
  end

  // One compare-and-subtract serves both the square root and the long division.
  always_comb begin
    if (state_q == S_SQRT) begin
      unit_a = {1'b0, x_q};
      unit_b = {1'b0, root_q} + {1'b0, bit_q};
    end else begin
      unit_a = {{(UNIT_W-NORM_W-1){1'b0}}, rem_q, low_q[VAL_W-1]};
      unit_b = {{(UNIT_W-NORM_W){1'b0}}, norm_q};
    end
  end

  gcn_cmp_sub u_cmp_sub (
    .a_i   (unit_a),
    .b_i   (unit_b),
    .res_o (unit_res)
  );

  assign square    = mag_q * mag_q;
  assign rd_mag    = rd_q[VAL_W-1] ? (~rd_q + VAL_W'(1)) : rd_q;
  assign prod      = rd_mag * max_norm_q;
  assign quot      = {low_q[VAL_W-2:0], unit_res.ge};
  assign elem_last = ({1'b0, idx_q} + (CW+1)'(1)) == {1'b0, count_q};

  always_comb begin
    state_d     = state_q;
    max_norm_d  = max_norm_q;
    count_d     = count_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    step_d      = step_q;
    mag_d       = mag_q;
    flush_d     = flush_q;
    x_d         = x_q;
    root_d      = root_q;
    bit_d       = bit_q;
    norm_d      = norm_q;
    clip_d      = clip_q;
    rem_d       = rem_q;
    low_d       = low_q;
    neg_d       = neg_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;

    if (cfg_valid_i && cfg_ready_o) begin
      max_norm_d = max_norm_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mag_d   = grad_value_i[VAL_W-1] ? (~grad_value_i + VAL_W'(1)) : grad_value_i;
          flush_d = is_last_i ||
                    (({1'b0, count_q} + (CW+1)'(1)) == (CW+1)'(VEC_DEPTH));
          count_d = count_q + CW'(1);
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d = sum_q + SUM_W'(square);
        if (flush_q) begin
          x_d     = sum_d;
          root_d  = '0;
          bit_d   = SQRT_BIT0;
          step_d  = '0;
          state_d = S_SQRT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SQRT: begin
        if (unit_res.ge) begin
          x_d    = unit_res.diff[SUM_W-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          norm_d  = root_d[NORM_W-1:0];
          idx_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        // The norm limit only changes while idle, so this is stable for the run.
        clip_d  = norm_q > {1'b0, max_norm_q};
        state_d = S_MUL;
      end
      S_MUL: begin
        out_last_d = elem_last;
        if (clip_q) begin
          // The quotient is below 2^24, so the upper product bits are below the norm.
          rem_d   = NORM_W'(prod[PROD_W-1:VAL_W]);
          low_d   = prod[VAL_W-1:0];
          neg_d   = rd_q[VAL_W-1];
          step_d  = '0;
          state_d = S_DIV;
        end else begin
          out_value_d = rd_q;
          state_d     = S_OUT;
        end
      end
      S_DIV: begin
        if (unit_res.ge) begin
          rem_d = unit_res.diff[NORM_W-1:0];
        end else begin
          rem_d = unit_a[NORM_W-1:0];
        end
        low_d  = quot;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          out_value_d = neg_q ? (~quot + VAL_W'(1)) : quot;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_fire) begin
          if (out_last_q) begin
            sum_d   = '0;
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      max_norm_q <= MAX_NORM_RST;
      count_q    <= '0;
      idx_q      <= '0;
      sum_q      <= '0;
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      max_norm_q <= max_norm_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      sum_q      <= sum_d;
      step_q     <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    flush_q     <= flush_d;
    x_q         <= x_d;
    root_q      <= root_d;
    bit_q       <= bit_d;
    norm_q      <= norm_d;
    clip_q      <= clip_d;
    rem_q       <= rem_d;
    low_q       <= low_d;
    neg_q       <= neg_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, count_q} <= (CW+1)'(VEC_DEPTH))
    else $error("element count beyond store depth");

  // A result is only shown for an element that was stored in this run.
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0) && (idx_q < count_q))
    else $error("result index outside the stored run");

  // A clipped run divides by the norm, which then cannot be zero.
  a_clip_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_clipped_o) |-> (vector_norm_o != '0))
    else $error("clipped run with zero norm");

  // Delivering the final result of a run clears the vector state.
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last_o) |=> (count_q == '0) && (sum_q == '0) && in_ready_o)
    else $error("vector state not cleared after the final result");

endmodule

// File: src/gcn_cmp_sub.sv
// Shared compare-and-subtract unit used by the square root and the divider.
module gcn_cmp_sub
  import gcn_pkg::*;
(
  input  logic [UNIT_W-1:0] a_i,
  input  logic [UNIT_W-1:0] b_i,
  output cs_res_t           res_o
);

  logic [UNIT_W:0] wide_diff;

  // The borrow out of the subtraction tells whether a is below b.
  assign wide_diff  = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~wide_diff[UNIT_W];
  assign res_o.diff = wide_diff[UNIT_W-1:0];

endmodule
